@@ src/dtcp_pkg.sv @@
// shared types, character codes and helpers of the decimal text command parser
package dtcp_pkg;

    localparam int MAX_LINE_CHARS_DEF  = 30;
    localparam int FRACTION_DIGITS_DEF = 3;

    localparam int VALUE_W = 32;
    localparam int KIND_W  = 3;
    // packed output fields rounded up to whole bytes
    localparam int OUT_FIELDS_W = KIND_W + VALUE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_T     = 8'h54;

    typedef enum logic [KIND_W-1:0] {
        KIND_PEDAL = 3'd0,
        KIND_TEMP  = 3'd1,
        KIND_SPEED = 3'd2,
        KIND_RESET = 3'd3,
        KIND_ACK   = 3'd4
    } t_kind;

    typedef struct packed {
        logic                       valid;
        t_kind                      kind;
        logic signed [VALUE_W-1:0]  value;
    } t_result;

    // 10^e for the fraction scaling, e up to six
    function automatic logic [19:0] pow10(input logic [2:0] e);
        logic [19:0] p;
        unique case (e)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

@@ src/dtcp_parse_core.sv @@
// line state, fixed point accumulator and result formation for one byte per step
module dtcp_parse_core #(
    parameter int MAX_LINE_CHARS  = dtcp_pkg::MAX_LINE_CHARS_DEF,
    parameter int FRACTION_DIGITS = dtcp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output dtcp_pkg::t_result o_result
);
    import dtcp_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);
    localparam int FCNT_W = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam int ACC_W = VALUE_W;       // magnitude held at or below 2^31
    localparam int WIDE_W = ACC_W + 4;
    localparam logic [WIDE_W-1:0] MAG_LIMIT = WIDE_W'(64'h8000_0000);

    logic [LEN_W-1:0]  r_len,    n_len;
    logic [7:0]        r_letter, n_letter;
    logic              r_neg,    n_neg;
    logic              r_point,  n_point;
    logic              r_ended,  n_ended;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic [FCNT_W-1:0] r_fcnt,   n_fcnt;

    logic              is_eol;
    logic              is_digit;
    logic [3:0]        digit;
    logic [WIDE_W-1:0] acc_sum;
    t_kind             kind;
    logic [ACC_W-1:0]  neg_val;

    assign is_eol   = (i_byte == CHAR_LF) || (i_byte == CHAR_CR);
    assign is_digit = (i_byte >= CHAR_0) && (i_byte <= CHAR_9);
    assign digit    = 4'(i_byte - CHAR_0);

    always_comb begin
        n_len    = r_len;
        n_letter = r_letter;
        n_neg    = r_neg;
        n_point  = r_point;
        n_ended  = r_ended;
        n_acc    = r_acc;
        n_fcnt   = r_fcnt;
        acc_sum  = WIDE_W'(r_acc);
        if (is_eol) begin
            if (r_len != '0) begin
                n_len    = '0;
                n_letter = '0;
                n_neg    = 1'b0;
                n_point  = 1'b0;
                n_ended  = 1'b0;
                n_acc    = '0;
                n_fcnt   = '0;
            end
        end else if (r_len < LEN_W'(MAX_LINE_CHARS)) begin
            n_len = r_len + LEN_W'(1);
            if (r_len == '0) begin
                n_letter = i_byte;
            end else if (!r_ended) begin
                priority if (i_byte == CHAR_NUL) begin
                    n_ended = 1'b1;
                end else if (i_byte == CHAR_MINUS && r_len == LEN_W'(1)) begin
                    n_neg = 1'b1;
                end else if (i_byte == CHAR_POINT) begin
                    n_point = 1'b1;
                end else if (is_digit) begin
                    if (!r_point) begin
                        acc_sum = WIDE_W'(r_acc) * WIDE_W'(10)
                                + WIDE_W'(digit) * WIDE_W'(pow10(3'(FRACTION_DIGITS)));
                    end else if (int'(r_fcnt) < FRACTION_DIGITS) begin
                        n_fcnt  = r_fcnt + FCNT_W'(1);
                        acc_sum = WIDE_W'(r_acc) + WIDE_W'(digit)
                                * WIDE_W'(pow10(3'(FRACTION_DIGITS - 1 - int'(r_fcnt))));
                    end
                    n_acc = (acc_sum > MAG_LIMIT) ? MAG_LIMIT[ACC_W-1:0]
                                                  : acc_sum[ACC_W-1:0];
                end else begin
                    // any other character leaves the value as it is
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_letter <= '0;
            r_neg    <= 1'b0;
            r_point  <= 1'b0;
            r_ended  <= 1'b0;
            r_acc    <= '0;
            r_fcnt   <= '0;
        end else if (i_step) begin
            r_len    <= n_len;
            r_letter <= n_letter;
            r_neg    <= n_neg;
            r_point  <= n_point;
            r_ended  <= n_ended;
            r_acc    <= n_acc;
            r_fcnt   <= n_fcnt;
        end
    end

    always_comb begin
        unique case (r_letter)
            CHAR_P:  kind = KIND_PEDAL;
            CHAR_T:  kind = KIND_TEMP;
            CHAR_S:  kind = KIND_SPEED;
            CHAR_R:  kind = KIND_RESET;
            default: kind = KIND_ACK;
        endcase
    end

    // two's complement of the magnitude, 2^31 wraps to the negative limit
    assign neg_val = ACC_W'(0) - r_acc;

    always_comb begin
        o_result.valid = is_eol && (r_len != '0);
        o_result.kind  = kind;
        if (kind == KIND_RESET || kind == KIND_ACK) begin
            o_result.value = '0;
        end else if (r_neg) begin
            o_result.value = neg_val;
        end else if (r_acc[ACC_W-1]) begin
            o_result.value = {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            o_result.value = r_acc;
        end
    end

endmodule

@@ src/decimal_text_command_parser_top.sv @@
// decimal text command parser: stream in, input register, parse core, output register
//
// Usage
//   Slave channel (i_s_*) carries one received character per transfer. Master channel
//   (o_m_*) carries one result per line that held at least one stored character, given
//   when a CR or LF arrives: the command kind and the signed value in thousandths.
//   The first character of a line is the command letter; at most MAX_LINE_CHARS are
//   stored, further characters up to the line end are dropped.
// Throughput
//   one character per cycle is accepted while no line end waits in the input register; the parse
//   step for any other character runs in the cycle after its transfer, a single multiply by ten and
//   add on the accumulator; a result passes the input and then the output register to o_m_tvalid.
// Reset
//   i_rst_n is synchronous, active low; it clears the line state and empties the input
//   and output registers.
// Stall
//   while a result waits in the output register, the next character is still taken and
//   parsed; only a further line end waits in the input register, which then holds
//   o_s_tready low until the result is taken.
module decimal_text_command_parser_top #(
    parameter int MAX_LINE_CHARS  = dtcp_pkg::MAX_LINE_CHARS_DEF,
    parameter int FRACTION_DIGITS = dtcp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // [7:0] rx_byte
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [dtcp_pkg::OUT_DATA_W-1:0] o_m_tdata   // [2:0] command_kind, [34:3] value_milli
);
    import dtcp_pkg::*;

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_out_valid;
    t_kind                     r_out_kind;
    logic signed [VALUE_W-1:0] r_out_value;

    t_result core_res;
    logic    out_free;
    logic    advance;
    logic    in_xfer;

    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!core_res.valid || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    dtcp_parse_core #(
        .MAX_LINE_CHARS  (MAX_LINE_CHARS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res.valid) begin
            r_out_kind  <= core_res.kind;
            r_out_value <= core_res.value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, r_out_value, r_out_kind};

endmodule
